// ===== design/skc_pkg.sv =====
// shared types, constants and the arctangent step table for the scara kinematics block
// no dependencies
package skc_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF    = 32;
  localparam int COORD_W            = 28;
  localparam int LINK_W             = 27;
  localparam int ANGLE_OUT_W        = 32;
  localparam int STATUS_W           = 2;
  localparam int CFG_INDEX_W        = 1;
  localparam int FRAC               = 30;
  localparam int CORDIC_ITERS       = 30;
  localparam int DIV_STEPS          = 30;
  localparam int REDUCE_STEPS       = 24;
  localparam int QUEUE_DEPTH        = 2;

  // angles are radians scaled by 2^30
  localparam logic signed [63:0] PI_F   = 64'sd3373259426;
  localparam logic signed [63:0] TURN_F = 64'sd6746518852;
  localparam logic signed [63:0] ONE_F  = 64'sd1 <<< FRAC;

  // operation codes
  localparam logic OP_SOLVE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNREACH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_ONE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_TWO = 1'd1;

  // classified item held between front and back
  typedef struct packed {
    logic                      clear;
    logic                      center;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } skc_item_t;

  // atan(2^-i) scaled by 2^30, rounded
  function automatic logic signed [63:0] step_angle(input logic [4:0] i);
    logic signed [63:0] a;
    case (i)
      5'd0: a = 64'sd843314857;
      5'd1: a = 64'sd497837829;
      5'd2: a = 64'sd263043837;
      5'd3: a = 64'sd133525159;
      5'd4: a = 64'sd67021688;
      5'd5: a = 64'sd33543516;
      5'd6: a = 64'sd16775851;
      5'd7: a = 64'sd8388437;
      5'd8: a = 64'sd4194283;
      5'd9: a = 64'sd2097149;
      default: a = 64'sd1 <<< (FRAC - int'(i));
    endcase
    return a;
  endfunction

endpackage

// ===== design/skc_in_if.sv =====
// input channel: operation and target point with valid/ready handshake
// depends on skc_pkg
interface skc_in_if;
  import skc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  modport source(output valid, operation, target_x, target_y, input ready);
  modport sink(input valid, operation, target_x, target_y, output ready);
endinterface

// ===== design/skc_out_if.sv =====
// result channel: joint angles and status with valid/ready handshake
// depends on skc_pkg
interface skc_out_if;
  import skc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_OUT_W-1:0] joint_one_angle;
  logic signed [ANGLE_OUT_W-1:0] joint_two_angle;
  logic [STATUS_W-1:0]           status;
  modport source(output valid, joint_one_angle, joint_two_angle, status, input ready);
  modport sink(input valid, joint_one_angle, joint_two_angle, status, output ready);
endinterface

// ===== design/scara_inverse_kinematics_unwrap.sv =====
// two-link scara inverse kinematics with joint angle unwrapping, top level
// the serial square root, ratio divider and cordic units set the solve time
// throughput: one transaction at a time through the solver, the next starts in the cycle after
// a result is registered; a two-entry queue takes new input meanwhile
// reset (rst_n, synchronous): link lengths and stored angles go to zero, queue and result empty
module scara_inverse_kinematics_unwrap #(
  parameter int POSITION_WIDTH = skc_pkg::POSITION_WIDTH_DEF,
  parameter int ANGLE_WIDTH    = skc_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  skc_in_if.sink                          in_stream,
  skc_out_if.source                       out_stream,
  input  logic                            cfg_we,
  input  logic [skc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [skc_pkg::LINK_W-1:0]      cfg_data
);
  import skc_pkg::*;

  logic [LINK_W-1:0] link_one_r;
  logic [LINK_W-1:0] link_two_r;
  logic              push;
  skc_item_t         push_item;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  skc_item_t         q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_one_r <= '0;
      link_two_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINK_ONE: link_one_r <= cfg_data;
        REG_LINK_TWO: link_two_r <= cfg_data;
        default: ;
      endcase
    end
  end

  skc_front #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_front (
    .in_stream (in_stream),
    .q_full    (q_full),
    .push      (push),
    .item      (push_item)
  );

  skc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  skc_back #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .link_one   (link_one_r),
    .link_two   (link_two_r),
    .out_stream (out_stream)
  );

endmodule

// ===== design/skc_queue.sv =====
// two-entry queue of classified items between front and back
// depends on skc_pkg
module skc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  skc_pkg::skc_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output skc_pkg::skc_item_t head
);
  import skc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  skc_item_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [PTR_W:0]      count_r;

  assign full  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== design/skc_front.sv =====
// front end: takes input transactions, clamps the target and flags clear and centre items
// depends on skc_pkg, skc_in_if
module skc_front #(
  parameter int POSITION_WIDTH = skc_pkg::POSITION_WIDTH_DEF
) (
  skc_in_if.sink            in_stream,
  input  logic              q_full,
  output logic              push,
  output skc_pkg::skc_item_t item
);
  import skc_pkg::*;

  localparam logic signed [48:0] POS_MAX = (49'sd1 <<< (POSITION_WIDTH - 1)) - 49'sd1;
  localparam logic signed [48:0] POS_MIN = -(49'sd1 <<< (POSITION_WIDTH - 1));

  function automatic logic signed [COORD_W-1:0] clamp_pos(input logic signed [COORD_W-1:0] v);
    logic signed [48:0] w;
    w = 49'(v);
    if (w > POS_MAX) begin
      w = POS_MAX;
    end else if (w < POS_MIN) begin
      w = POS_MIN;
    end
    return COORD_W'(w);
  endfunction

  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;

  // classify
  always_comb begin
    cx          = clamp_pos(in_stream.target_x);
    cy          = clamp_pos(in_stream.target_y);
    item.clear  = (in_stream.operation == OP_CLEAR);
    item.center = (cx == '0) && (cy == '0);
    item.x      = cx;
    item.y      = cy;
  end

  assign in_stream.ready = !q_full;
  assign push            = in_stream.valid && !q_full;

endmodule

// ===== design/skc_cordic.sv =====
// vectoring cordic: angle of (x, y), one iteration per cycle
// depends on skc_pkg
module skc_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  output logic               busy,
  output logic signed [63:0] angle
);
  import skc_pkg::*;

  logic signed [63:0] x_r;
  logic signed [63:0] y_r;
  logic signed [63:0] z_r;
  logic [4:0]         i_r;
  logic               busy_r;
  logic signed [63:0] xs;
  logic signed [63:0] ys;

  assign busy  = busy_r;
  assign angle = z_r;
  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      i_r <= '0;
      if (x_in < 0) begin
        z_r <= (y_in >= 0) ? PI_F : -PI_F;
        x_r <= -x_in;
        y_r <= -y_in;
      end else begin
        z_r <= '0;
        x_r <= x_in;
        y_r <= y_in;
      end
    end else if (busy_r) begin
      i_r <= i_r + 1'b1;
      // rotate toward y = 0, zero counts as negative
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + step_angle(i_r);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - step_angle(i_r);
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (i_r == 5'(CORDIC_ITERS - 1))) begin
      busy_r <= 1'b0;
    end
  end

endmodule

// ===== design/skc_root.sv =====
// integer square root, one result bit per cycle
// depends on skc_pkg
module skc_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        busy,
  output logic [31:0] root
);
  import skc_pkg::*;

  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic        busy_r;
  logic [63:0] trial;

  assign busy  = busy_r;
  assign root  = res_r[31:0];
  assign trial = res_r + bit_r;

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= arg;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

endmodule

// ===== design/skc_div.sv =====
// cosine ratio divider: signed quotient in q1.30, saturating at one, one bit per cycle
// depends on skc_pkg
module skc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [63:0]        den,
  output logic               busy,
  output logic signed [63:0] quo
);
  import skc_pkg::*;

  logic [63:0]    rem_r;
  logic [63:0]    den_r;
  logic [FRAC:0]  q_r;
  logic           neg_r;
  logic [4:0]     cnt_r;
  logic           busy_r;
  logic [63:0]    mag;
  logic [63:0]    rem2;
  logic signed [63:0] qs;

  assign busy = busy_r;
  assign mag  = (num < 0) ? 64'(-num) : 64'(num);
  assign rem2 = rem_r << 1;
  assign qs   = 64'(q_r);
  assign quo  = neg_r ? -qs : qs;

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= mag;
      cnt_r <= '0;
      if (den == '0) begin
        // degenerate link: cosine taken as one
        neg_r <= 1'b0;
        q_r   <= (FRAC+1)'(ONE_F);
      end else if (mag >= den) begin
        neg_r <= (num < 0);
        q_r   <= (FRAC+1)'(ONE_F);
      end else begin
        neg_r <= (num < 0);
        q_r   <= '0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (rem2 >= den_r) begin
        rem_r <= rem2 - den_r;
        q_r   <= {q_r[FRAC-1:0], 1'b1};
      end else begin
        rem_r <= rem2;
        q_r   <= {q_r[FRAC-1:0], 1'b0};
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= (den != '0) && (mag < den);
    end else if (busy_r && (cnt_r == 5'(DIV_STEPS - 1))) begin
      busy_r <= 1'b0;
    end
  end

endmodule

// ===== design/skc_back.sv =====
// back end: sequencer that solves the joints, unwraps them, keeps the stored angles
// depends on skc_pkg, skc_out_if, skc_cordic, skc_root, skc_div
module skc_back #(
  parameter int ANGLE_WIDTH = skc_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  skc_pkg::skc_item_t         q_head,
  output logic                       q_pop,
  input  logic [skc_pkg::LINK_W-1:0] link_one,
  input  logic [skc_pkg::LINK_W-1:0] link_two,
  skc_out_if.source                  out_stream
);
  import skc_pkg::*;

  localparam logic signed [63:0] ANG_MAX = (64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] ANG_MIN = -(64'sd1 <<< (ANGLE_WIDTH - 1));
  localparam logic [63:0]        TURN_TOP = 64'(TURN_F) << (REDUCE_STEPS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_REACH, S_GAP, S_CHECK, S_L2SQ, S_RWAIT, S_DEN1,
    S_DIV, S_DWAIT, S_ACM, S_ACR, S_ACRW, S_ACC, S_ACCW,
    S_UINIT, S_URED, S_UFIN, S_FINAL, S_OUT
  } state_t;

  state_t                    state_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic [63:0]               r2_r;
  logic [63:0]               reach2_r;
  logic [63:0]               ll1_r;
  logic [63:0]               ll2_r;
  logic [31:0]               r_r;
  logic [63:0]               prod_r;
  logic                      phase_r;
  logic signed [63:0]        c_r;
  logic signed [63:0]        j1_r;
  logic signed [63:0]        j2_r;
  logic                      sel_r;
  logic [63:0]               mag_r;
  logic                      neg_r;
  logic [63:0]               tsh_r;
  logic [4:0]                k_r;
  logic signed [63:0]        n1_r;
  logic signed [63:0]        n2_r;
  logic signed [ANGLE_WIDTH-1:0] prev1_r;
  logic signed [ANGLE_WIDTH-1:0] prev2_r;
  logic [STATUS_W-1:0]       status_r;
  logic                      out_valid_r;
  logic signed [ANGLE_OUT_W-1:0] out_j1_r;
  logic signed [ANGLE_OUT_W-1:0] out_j2_r;
  logic [STATUS_W-1:0]       out_status_r;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        ax;
  logic [31:0]        ay;
  logic [31:0]        cmag;
  logic [LINK_W:0]    reach;
  logic [LINK_W-1:0]  gap;
  logic signed [63:0] num;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [63:0] pv;
  logic signed [63:0] ua;
  logic signed [63:0] ud;
  logic signed [63:0] unew;
  logic               out_free;

  logic               cordic_start;
  logic signed [63:0] cordic_x;
  logic signed [63:0] cordic_y;
  logic               cordic_busy;
  logic signed [63:0] cordic_angle;
  logic               root_start;
  logic [63:0]        root_arg;
  logic               root_busy;
  logic [31:0]        root_res;
  logic               div_start;
  logic               div_busy;
  logic signed [63:0] div_quo;

  skc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (cordic_x),
    .y_in  (cordic_y),
    .busy  (cordic_busy),
    .angle (cordic_angle)
  );

  skc_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .arg   (root_arg),
    .busy  (root_busy),
    .root  (root_res)
  );

  skc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (prod_r << 1),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // operand magnitudes, link sum and difference, and the cosine numerator
  always_comb begin
    ax    = 32'(x_r[COORD_W-1] ? -(COORD_W+1)'(x_r) : (COORD_W+1)'(x_r));
    ay    = 32'(y_r[COORD_W-1] ? -(COORD_W+1)'(y_r) : (COORD_W+1)'(y_r));
    cmag  = 32'((c_r < 0) ? -c_r : c_r);
    reach = (LINK_W+1)'(link_one) + (LINK_W+1)'(link_two);
    gap   = (link_one > link_two) ? link_one - link_two : link_two - link_one;
    num   = phase_r ? $signed(ll1_r + ll2_r) - $signed(r2_r)
                    : $signed(ll1_r + r2_r) - $signed(ll2_r);
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_SQX:          begin mul_a = ax;               mul_b = ax;               end
      S_SQY:          begin mul_a = ay;               mul_b = ay;               end
      S_REACH:        begin mul_a = 32'(reach);       mul_b = 32'(reach);       end
      S_GAP:          begin mul_a = 32'(gap);         mul_b = 32'(gap);         end
      S_CHECK:        begin mul_a = 32'(link_one);    mul_b = 32'(link_one);    end
      S_L2SQ, S_RWAIT: begin mul_a = 32'(link_two);   mul_b = 32'(link_two);    end
      S_DEN1:         begin mul_a = 32'(link_one);    mul_b = r_r;              end
      S_ACCW:         begin mul_a = 32'(link_one);    mul_b = 32'(link_two);    end
      S_ACM:          begin mul_a = cmag;             mul_b = cmag;             end
      default:        begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  // unit start controls
  always_comb begin
    cordic_start = 1'b0;
    cordic_x     = c_r;
    cordic_y     = 64'(root_res);
    root_start   = 1'b0;
    root_arg     = (64'd1 << 60) - prod_r;
    div_start    = (state_r == S_DIV);
    case (state_r)
      S_CHECK: begin
        if (!(r2_r > reach2_r || r2_r < prod_r) && !(x_r == '0 && y_r == '0)) begin
          cordic_start = 1'b1;
          cordic_x     = 64'(x_r) <<< 16;
          cordic_y     = 64'(y_r) <<< 16;
          root_start   = 1'b1;
          root_arg     = r2_r;
        end
      end
      S_ACR:   root_start   = 1'b1;
      S_ACC:   cordic_start = 1'b1;
      default: ;
    endcase
  end

  // unwrap arithmetic
  always_comb begin
    p1 = 64'(prev1_r);
    p2 = 64'(prev2_r);
    pv = sel_r ? p2 : p1;
    ua = (sel_r ? j2_r : j1_r) - (pv <<< 6);
    ud = (neg_r && (mag_r != '0)) ? TURN_F - $signed(mag_r) : $signed(mag_r);
    if (ud > PI_F) begin
      ud = ud - TURN_F;
    end
    unew = pv + ((ud + 64'sd32) >>> 6);
  end

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || out_stream.ready;

  assign out_stream.valid           = out_valid_r;
  assign out_stream.joint_one_angle = out_j1_r;
  assign out_stream.joint_two_angle = out_j2_r;
  assign out_stream.status          = out_status_r;

  // multiplier register
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev1_r      <= '0;
      prev2_r      <= '0;
      out_valid_r  <= 1'b0;
      status_r     <= STATUS_OK;
    end else begin
      if (out_valid_r && out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            x_r <= q_head.x;
            y_r <= q_head.y;
            if (q_head.clear) begin
              prev1_r  <= '0;
              prev2_r  <= '0;
              status_r <= STATUS_OK;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_SQX;
            end
          end
        end
        S_SQX:   state_r <= S_SQY;
        S_SQY: begin
          r2_r    <= prod_r;
          state_r <= S_REACH;
        end
        S_REACH: begin
          r2_r    <= r2_r + prod_r;
          state_r <= S_GAP;
        end
        S_GAP: begin
          reach2_r <= prod_r;
          state_r  <= S_CHECK;
        end
        S_CHECK: begin
          if (r2_r > reach2_r || r2_r < prod_r) begin
            status_r <= STATUS_UNREACH;
            state_r  <= S_OUT;
          end else if (x_r == '0 && y_r == '0) begin
            // centre: keep joint one, joint two half a turn on
            j1_r    <= p1 <<< 6;
            j2_r    <= (p1 <<< 6) + PI_F;
            sel_r   <= 1'b0;
            state_r <= S_UINIT;
          end else begin
            state_r <= S_L2SQ;
          end
        end
        S_L2SQ: begin
          ll1_r   <= prod_r;
          state_r <= S_RWAIT;
        end
        S_RWAIT: begin
          if (!root_busy && !cordic_busy) begin
            ll2_r   <= prod_r;
            r_r     <= root_res;
            j1_r    <= cordic_angle;
            phase_r <= 1'b0;
            state_r <= S_DEN1;
          end
        end
        S_DEN1:  state_r <= S_DIV;
        S_DIV:   state_r <= S_DWAIT;
        S_DWAIT: begin
          if (!div_busy) begin
            c_r     <= div_quo;
            state_r <= S_ACM;
          end
        end
        S_ACM:   state_r <= S_ACR;
        S_ACR:   state_r <= S_ACRW;
        S_ACRW: begin
          if (!root_busy) begin
            state_r <= S_ACC;
          end
        end
        S_ACC:   state_r <= S_ACCW;
        S_ACCW: begin
          if (!cordic_busy) begin
            if (!phase_r) begin
              j1_r    <= j1_r - cordic_angle;
              phase_r <= 1'b1;
              state_r <= S_DIV;
            end else begin
              j2_r    <= PI_F + j1_r - cordic_angle;
              sel_r   <= 1'b0;
              state_r <= S_UINIT;
            end
          end
        end
        // unwrap: reduce the difference modulo a turn by shifted subtraction
        S_UINIT: begin
          neg_r   <= (ua < 0);
          mag_r   <= (ua < 0) ? 64'(-ua) : 64'(ua);
          tsh_r   <= TURN_TOP;
          k_r     <= 5'(REDUCE_STEPS - 1);
          state_r <= S_URED;
        end
        S_URED: begin
          if (mag_r >= tsh_r) begin
            mag_r <= mag_r - tsh_r;
          end
          tsh_r <= tsh_r >> 1;
          k_r   <= k_r - 1'b1;
          if (k_r == '0) begin
            state_r <= S_UFIN;
          end
        end
        S_UFIN: begin
          if (!sel_r) begin
            n1_r    <= unew;
            sel_r   <= 1'b1;
            state_r <= S_UINIT;
          end else begin
            n2_r    <= unew;
            state_r <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (n1_r > ANG_MAX || n1_r < ANG_MIN || n2_r > ANG_MAX || n2_r < ANG_MIN) begin
            status_r <= STATUS_RANGE;
          end else begin
            prev1_r  <= ANGLE_WIDTH'(n1_r);
            prev2_r  <= ANGLE_WIDTH'(n2_r);
            status_r <= STATUS_OK;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_j1_r     <= ANGLE_OUT_W'(p1);
            out_j2_r     <= ANGLE_OUT_W'(p2);
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
